/* design/psa_pkg.sv */
`timescale 1ns / 1ps

package psa_pkg;

	localparam int P_W         = 21;   // pressure sample / average
	localparam int T_W         = 13;   // kelvin input
	localparam int TC_W        = 14;   // celsius result
	localparam int SUM_W       = 26;   // running sum
	localparam int CNT_W       = 6;    // sample count
	localparam int WINDOW_LEN  = 32;   // count at which sum and count are halved
	localparam int KELVIN_OFFSET = 4370; // 273.125 K in 1/16 K
	localparam int STEP_W      = $clog2(SUM_W);

	typedef enum logic [1:0] {
		MODE_PRESSURE = 2'd0,
		MODE_TEMP     = 2'd1,
		MODE_READ     = 2'd2
	} mode_t;

	// serial accumulator controls
	typedef struct packed {
		logic load;   // capture addend, clear carry
		logic shift;  // one bit of the serial add
		logic halve;  // sum >> 1
		logic clear;  // sum <= 0
	} acc_ctrl_t;

	// serial divider controls
	typedef struct packed {
		logic start;  // load dividend and divisor
		logic step;   // one quotient bit
	} div_ctrl_t;

endpackage

/* design/psa_serial_acc.sv */
`timescale 1ns / 1ps

module psa_serial_acc import psa_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  acc_ctrl_t        ctrl,
	input  logic [P_W-1:0]   sample,
	output logic [SUM_W-1:0] sum
);

	logic [SUM_W-1:0] sum_q;
	logic [SUM_W-1:0] addend_q;
	logic             carry_q;
	logic             sum_bit;
	logic             carry_nxt;

	// full adder on the low bits; sum rotates LSB first, back in place after SUM_W shifts
	assign sum_bit   = sum_q[0] ^ addend_q[0] ^ carry_q;
	assign carry_nxt = (sum_q[0] & addend_q[0]) | (carry_q & (sum_q[0] ^ addend_q[0]));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			carry_q <= 1'b0;
		end else begin
			if (ctrl.load) begin
				carry_q <= 1'b0;
			end else if (ctrl.shift) begin
				sum_q   <= {sum_bit, sum_q[SUM_W-1:1]};
				carry_q <= carry_nxt;
			end else if (ctrl.halve) begin
				sum_q <= {1'b0, sum_q[SUM_W-1:1]};
			end else if (ctrl.clear) begin
				sum_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			addend_q <= SUM_W'(sample);
		end else if (ctrl.shift) begin
			addend_q <= {1'b0, addend_q[SUM_W-1:1]};
		end
	end

	assign sum = sum_q;

endmodule

/* design/psa_serial_div.sv */
`timescale 1ns / 1ps

module psa_serial_div import psa_pkg::*; (
	input  logic             clk,
	input  div_ctrl_t        ctrl,
	input  logic [SUM_W-1:0] dividend,
	input  logic [CNT_W-1:0] divisor,
	output logic [SUM_W-1:0] quotient
);

	logic [CNT_W-1:0] rem_q;
	logic [SUM_W-1:0] quo_q;
	logic [CNT_W-1:0] dvs_q;
	logic [CNT_W:0]   shifted;
	logic [CNT_W+1:0] diff;
	logic             neg;

	// restoring division, one quotient bit per step, MSB first
	assign shifted = {rem_q, quo_q[SUM_W-1]};
	assign diff    = {1'b0, shifted} - {2'b00, dvs_q};
	assign neg     = diff[CNT_W+1];

	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (ctrl.step) begin
			rem_q <= neg ? shifted[CNT_W-1:0] : diff[CNT_W-1:0];
			quo_q <= {quo_q[SUM_W-2:0], ~neg};
		end
	end

	assign quotient = quo_q;

endmodule

/* design/pressure_sample_averager_unit.sv */
`timescale 1ns / 1ps

// Channel  | handshake            | payload
// ---------+----------------------+----------------------------------------------
// request  | req_valid, req_stall | mode, pressure_sample, temperature_kelvin
// result   | res_valid, res_stall | valid_res, pressure_avg, temperature_celsius
//
// One item at a time. Pressure item: accept in ST_IDLE, serial add in ST_ADD,
// ST_HALVE when the count hits WINDOW_LEN and sum/count are halved, then post.
// Read with data: accept, restoring divide in ST_DIV, post. Others: accept, post.
// The 26-bit sum width sets both serial loops.
// Async reset clears sum, count, flag, temperature and the result valid flag.
// A finished result waits in the output register while the next request transfer
// is taken; only the post of that next result waits on res_stall.

module pressure_sample_averager_unit import psa_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   req_valid,
	output logic                   req_stall,
	input  logic [1:0]             mode,
	input  logic [P_W-1:0]         pressure_sample,
	input  logic [T_W-1:0]         temperature_kelvin,
	output logic                   res_valid,
	input  logic                   res_stall,
	output logic                   valid_res,
	output logic [P_W-1:0]         pressure_avg,
	output logic signed [TC_W-1:0] temperature_celsius
);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_ADD   = 5'b00010,
		ST_HALVE = 5'b00100,
		ST_DIV   = 5'b01000,
		ST_DONE  = 5'b10000
	} state_t;

	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SUM_W - 1);

	state_t            state_q;
	logic [STEP_W-1:0] step_q;
	logic [CNT_W-1:0]  count_q;
	logic              flag_q;       // new pressure data since last read
	logic [TC_W-1:0]   last_temp_q;
	logic              pend_vld_q;   // pending result is a valid read
	logic              pend_div_q;   // pending result takes the quotient
	logic              res_valid_q;
	logic              valid_res_q;
	logic [P_W-1:0]    avg_q;
	logic [TC_W-1:0]   temp_out_q;

	logic              take;
	logic              post;
	logic              read_div;
	acc_ctrl_t         acc_ctrl;
	div_ctrl_t         div_ctrl;
	logic [SUM_W-1:0]  sum;
	logic [SUM_W-1:0]  quotient;

	assign req_stall = (state_q != ST_IDLE);
	assign take      = req_valid && (state_q == ST_IDLE);
	// result register free or being emptied this cycle
	assign post      = (state_q == ST_DONE) && (!res_valid_q || !res_stall);
	// read that actually divides: new data and a nonzero count
	assign read_div  = take && (mode_t'(mode) == MODE_READ) && flag_q && (count_q != '0);

	always_comb begin
		acc_ctrl.load  = take && (mode_t'(mode) == MODE_PRESSURE);
		acc_ctrl.shift = (state_q == ST_ADD);
		acc_ctrl.halve = (state_q == ST_HALVE);
		acc_ctrl.clear = read_div;
		div_ctrl.start = read_div;
		div_ctrl.step  = (state_q == ST_DIV);
	end

	psa_serial_acc u_acc (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (acc_ctrl),
		.sample (pressure_sample),
		.sum    (sum)
	);

	psa_serial_div u_div (
		.clk      (clk),
		.ctrl     (div_ctrl),
		.dividend (sum),
		.divisor  (count_q),
		.quotient (quotient)
	);

	// sequencer and averager state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			count_q     <= '0;
			flag_q      <= 1'b0;
			last_temp_q <= '0;
			pend_vld_q  <= 1'b0;
			pend_div_q  <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (post) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && !res_stall) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (take) begin
						pend_vld_q <= (mode_t'(mode) == MODE_READ) && flag_q;
						pend_div_q <= read_div;
						step_q     <= '0;
						case (mode_t'(mode))
							MODE_PRESSURE: begin
								count_q <= count_q + CNT_W'(1);
								flag_q  <= 1'b1;
								state_q <= ST_ADD;
							end
							MODE_TEMP: begin
								last_temp_q <= TC_W'(temperature_kelvin) - TC_W'(KELVIN_OFFSET);
								state_q     <= ST_DONE;
							end
							MODE_READ: begin
								flag_q <= 1'b0;
								if (read_div) begin
									count_q <= '0;
									state_q <= ST_DIV;
								end else begin
									state_q <= ST_DONE;
								end
							end
							default: begin
								state_q <= ST_DONE;
							end
						endcase
					end
				end
				ST_ADD: begin
					step_q <= step_q + STEP_W'(1);
					if (step_q == LAST_STEP) begin
						state_q <= (count_q == CNT_W'(WINDOW_LEN)) ? ST_HALVE : ST_DONE;
					end
				end
				ST_HALVE: begin
					count_q <= CNT_W'(WINDOW_LEN / 2);
					state_q <= ST_DONE;
				end
				ST_DIV: begin
					step_q <= step_q + STEP_W'(1);
					if (step_q == LAST_STEP) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (post) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (post) begin
			valid_res_q <= pend_vld_q;
			avg_q       <= pend_div_q ? quotient[P_W-1:0] : '0;
			temp_out_q  <= pend_vld_q ? last_temp_q : '0;
		end
	end

	assign res_valid           = res_valid_q;
	assign valid_res           = valid_res_q;
	assign pressure_avg        = avg_q;
	assign temperature_celsius = signed'(temp_out_q);

	// count never passes the halving point
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(WINDOW_LEN))
		else $error("sample count above window length");

	// without new data there are no samples held
	a_flag_count: assert property (@(posedge clk) disable iff (!arst_n)
		!flag_q |-> (count_q == '0))
		else $error("samples held without new-data flag");

	// an invalid result carries zeros
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !valid_res) |-> (pressure_avg == '0 && temperature_celsius == '0))
		else $error("invalid result with nonzero payload");

	// average always fits the pressure field
	a_quot_fits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && step_q == LAST_STEP) |=> (quotient[SUM_W-1:P_W] == '0))
		else $error("quotient overflows pressure field");

endmodule
